// File: rtl/core/dbrs_pkg.sv
// Shared types and constants for the dirty-bitmap run scanner.
`default_nettype none

package dbrs_pkg;

	// Fixed field widths.
	localparam int WORD_BITS  = 32;
	localparam int ADDR_BITS  = 48;
	localparam int IDX_BITS   = 16;
	localparam int BYTES_BITS = 10;
	localparam int SLOT_BITS  = 20;
	localparam int CNT_BITS   = 21;
	localparam int LG_BITS    = 3;
	localparam int CFG_IDX_BITS = 2;

	// Smallest chunk size in use, as a log2.
	localparam logic [LG_BITS-1:0] LG_MIN = 3'd3;

	// Largest usable log capacity.
	localparam logic [CNT_BITS-1:0] CAP_MAX = 21'h100000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_STACK_BASE     = 2'd0,
		CFG_CHUNK_LOG_SIZE = 2'd1,
		CFG_LOG_CAPACITY   = 2'd2
	} cfg_idx_t;

	// Scanner states.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Request from the scanner to the log slot allocator.
	typedef struct packed {
		logic take;
		logic restart;
	} alloc_req_t;

	// Slot assignment for the record being issued.
	typedef struct packed {
		logic [SLOT_BITS-1:0] slot;
		logic                 overflow;
	} alloc_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/dirty_bitmap_run_scanner_top.sv
// Top level of the dirty-bitmap run scanner: configuration, bit-serial scan and record output.
`default_nettype none

// The scanner takes one item at a time. A scan item loads its 32-bit word into a shift
// register that is consumed from bit 0 upward, one window step per clock: a clean window
// or a full run moves RUN_CHUNKS positions at once, any other position moves one. An item
// therefore occupies the scanner for its load and then its scan steps until no set bit
// remains, and each record leaves through a single output register, so a step that
// produces a record waits while that register is still held by the consumer. A restart
// item or a clean word needs no scan step. The chunk address is kept by an accumulator
// that adds the step size in bytes on each step, so no per-record multiply is needed. A
// new item is taken as soon as the last step of the previous one has issued, even while
// its final record still waits on the output.
module dirty_bitmap_run_scanner_top #(
	parameter int WORD_INDEX_BITS = 16,
	parameter int RUN_CHUNKS      = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration write port.
	input  wire logic                                  cfg_we,
	input  wire logic [dbrs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [dbrs_pkg::ADDR_BITS-1:0]        cfg_wdata,
	// Input channel.
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  func,
	input  wire logic [dbrs_pkg::IDX_BITS-1:0]         word_index,
	input  wire logic [dbrs_pkg::WORD_BITS-1:0]        dirty_word,
	// Output channel.
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [dbrs_pkg::ADDR_BITS-1:0]             chunk_addr,
	output logic [dbrs_pkg::BYTES_BITS-1:0]            chunk_bytes,
	output logic [dbrs_pkg::SLOT_BITS-1:0]             log_slot,
	output logic                                       overflow,
	output logic                                       last
);

	localparam int IDX_USED = (WORD_INDEX_BITS < dbrs_pkg::IDX_BITS) ?
		WORD_INDEX_BITS : dbrs_pkg::IDX_BITS;
	localparam logic [dbrs_pkg::IDX_BITS-1:0] IDX_MASK =
		dbrs_pkg::IDX_BITS'((64'd1 << IDX_USED) - 64'd1);
	localparam logic [3:0] RUN_CNT = 4'(RUN_CHUNKS);

	// Configuration registers.
	logic [dbrs_pkg::ADDR_BITS-1:0] stack_base_q;
	logic [dbrs_pkg::LG_BITS-1:0]   clog_q;
	logic [dbrs_pkg::CNT_BITS-1:0]  log_capacity_q;

	// Scanner state.
	dbrs_pkg::state_t               state_q, state_d;
	logic [dbrs_pkg::WORD_BITS-1:0] sr_q, sr_d, sr_shift;
	logic [dbrs_pkg::ADDR_BITS-1:0] addr_q, addr_d, addr_start;
	logic [dbrs_pkg::IDX_BITS-1:0]  widx;
	logic [dbrs_pkg::LG_BITS-1:0]   lg;
	logic [RUN_CHUNKS-1:0]          win;
	logic [3:0]                     adv;
	logic [10:0]                    step_bytes;
	logic [10:0]                    rec_bytes;
	logic                           rec, load, out_free, in_fire;

	// Output register.
	logic                              out_valid_q;
	logic [dbrs_pkg::ADDR_BITS-1:0]    chunk_addr_q;
	logic [dbrs_pkg::BYTES_BITS-1:0]   chunk_bytes_q;
	logic [dbrs_pkg::SLOT_BITS-1:0]    log_slot_q;
	logic                              overflow_q;
	logic                              last_q;

	dbrs_pkg::alloc_req_t alloc_req;
	dbrs_pkg::alloc_rsp_t alloc_rsp;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_base_q   <= '0;
			clog_q         <= dbrs_pkg::LG_MIN;
			log_capacity_q <= '0;
		end else if (cfg_we) begin
			case (dbrs_pkg::cfg_idx_t'(cfg_index))
				dbrs_pkg::CFG_STACK_BASE:     stack_base_q   <= cfg_wdata;
				dbrs_pkg::CFG_CHUNK_LOG_SIZE: clog_q         <= cfg_wdata[dbrs_pkg::LG_BITS-1:0];
				dbrs_pkg::CFG_LOG_CAPACITY:   log_capacity_q <= cfg_wdata[dbrs_pkg::CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Chunk size is at least eight bytes.
	assign lg = (clog_q < dbrs_pkg::LG_MIN) ? dbrs_pkg::LG_MIN : clog_q;

	// Address of chunk zero of this word.
	assign widx       = word_index & IDX_MASK;
	assign addr_start = stack_base_q + (dbrs_pkg::ADDR_BITS'({widx, 5'b0}) << lg);

	assign in_ready = (state_q == dbrs_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Window rules at the current bit position.
	assign win      = sr_q[RUN_CHUNKS-1:0];
	always_comb begin
		rec = 1'b0;
		adv = 4'd1;
		if (state_q == dbrs_pkg::ST_SCAN) begin
			if (win == '0) begin
				adv = RUN_CNT;
			end else if (&win) begin
				adv = RUN_CNT;
				rec = 1'b1;
			end else if (win[0]) begin
				rec = 1'b1;
			end
		end
	end

	assign sr_shift   = (adv == RUN_CNT) ? (sr_q >> RUN_CHUNKS) : (sr_q >> 1);
	assign step_bytes = 11'(adv) << lg;
	assign rec_bytes  = step_bytes;
	assign load       = rec && out_free;

	// Next state: load a dirty word, then step until no set bit remains.
	always_comb begin
		state_d = state_q;
		sr_d    = sr_q;
		addr_d  = addr_q;
		case (state_q)
			dbrs_pkg::ST_IDLE: begin
				if (in_fire && !func && (dirty_word != '0)) begin
					sr_d    = dirty_word;
					addr_d  = addr_start;
					state_d = dbrs_pkg::ST_SCAN;
				end
			end
			dbrs_pkg::ST_SCAN: begin
				if (!rec || out_free) begin
					sr_d   = sr_shift;
					addr_d = addr_q + dbrs_pkg::ADDR_BITS'(step_bytes);
					if (sr_shift == '0) begin
						state_d = dbrs_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = dbrs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan datapath registers.
	always_ff @(posedge clk) begin
		sr_q   <= sr_d;
		addr_q <= addr_d;
	end

	// Log slot allocation.
	assign alloc_req.take    = load;
	assign alloc_req.restart = in_fire && func;

	dbrs_log_alloc u_alloc (
		.clk          (clk),
		.arst_n       (arst_n),
		.log_capacity (log_capacity_q),
		.req          (alloc_req),
		.rsp          (alloc_rsp)
	);

	// Output valid: set by a new record, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; a record is last when no set bit remains after its step.
	always_ff @(posedge clk) begin
		if (load) begin
			chunk_addr_q  <= addr_q;
			chunk_bytes_q <= rec_bytes[dbrs_pkg::BYTES_BITS-1:0];
			log_slot_q    <= alloc_rsp.slot;
			overflow_q    <= alloc_rsp.overflow;
			last_q        <= (sr_shift == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign chunk_addr  = chunk_addr_q;
	assign chunk_bytes = chunk_bytes_q;
	assign log_slot    = log_slot_q;
	assign overflow    = overflow_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	// While scanning, some set bit is always still ahead.
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dbrs_pkg::ST_SCAN) |-> (sr_q != '0))
		else $error("scanner active with an empty word");

	// Issuing the last record of a word returns the scanner to idle.
	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (sr_shift == '0)) |=> (state_q == dbrs_pkg::ST_IDLE))
		else $error("scanner kept running after the last record");

	// A record is never issued over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load)
		else $error("output record overwritten");

	// An overflow record carries slot zero.
	a_ovf_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overflow_q) |-> (log_slot_q == '0))
		else $error("overflow record with a nonzero slot");
`endif

endmodule

`default_nettype wire

// File: rtl/core/dbrs_log_alloc.sv
// Log slot allocator: fill counter, saturating overflow counter and capacity check.
`default_nettype none

module dbrs_log_alloc (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [dbrs_pkg::CNT_BITS-1:0]   log_capacity,
	input  wire dbrs_pkg::alloc_req_t            req,
	output dbrs_pkg::alloc_rsp_t                 rsp
);

	logic [dbrs_pkg::CNT_BITS-1:0] fill_q;
	logic [dbrs_pkg::CNT_BITS-1:0] extra_q;
	logic [dbrs_pkg::CNT_BITS-1:0] cap_eff;
	logic                          full;

	// Capacity is clamped to the size of the slot field.
	assign cap_eff = log_capacity[dbrs_pkg::CNT_BITS-1] ? dbrs_pkg::CAP_MAX : log_capacity;
	assign full    = (fill_q >= cap_eff);

	// Slot for the current record; an overflow record carries slot zero.
	always_comb begin
		rsp.overflow = full;
		rsp.slot     = full ? '0 : fill_q[dbrs_pkg::SLOT_BITS-1:0];
	end

	// Counters: a restart clears both, each record bumps one of them; the overflow counter saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			extra_q <= '0;
		end else if (req.restart) begin
			fill_q  <= '0;
			extra_q <= '0;
		end else if (req.take) begin
			if (full) begin
				if (extra_q != {dbrs_pkg::CNT_BITS{1'b1}}) begin
					extra_q <= extra_q + 1'b1;
				end
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
